[hw/rtl/mafhf_pkg.sv]
// Shared types, header constants and rate tables for the MPEG audio frame header finder.
`default_nettype none

package mafhf_pkg;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_MUL  = 4'b0010,
      ST_DIV  = 4'b0100,
      ST_PUSH = 4'b1000
   } state_type;

   localparam logic [0:0] REG_START_OFFSET = 1'b0;
   localparam logic [0:0] REG_STOP_FIRST   = 1'b1;

   localparam logic [7:0] SYNC_BYTE = 8'hFF;
   localparam logic [7:0] SYNC_MASK = 8'hE0;

   localparam logic [1:0] VER_BITS_MPEG1    = 2'd3;
   localparam logic [1:0] VER_BITS_MPEG2    = 2'd2;
   localparam logic [1:0] VER_BITS_RESERVED = 2'd1;
   localparam logic [1:0] LAY_BITS_RESERVED = 2'd0;
   localparam logic [3:0] BR_IDX_FREE       = 4'd0;
   localparam logic [3:0] BR_IDX_BAD        = 4'd15;
   localparam logic [1:0] SR_IDX_RESERVED   = 2'd3;

   localparam logic [1:0] VER_MPEG1  = 2'd0;
   localparam logic [1:0] VER_MPEG2  = 2'd1;
   localparam logic [1:0] VER_MPEG25 = 2'd2;
   localparam logic [1:0] LAYER_I    = 2'd0;

   localparam logic [17:0] SCALE_LAYER_I  = 18'd48000;
   localparam logic [17:0] SCALE_LAYER_23 = 18'd144000;

   localparam int unsigned QUOT_BITS = 12;
   localparam int unsigned NUM_BITS  = 26;
   localparam int unsigned RSP_BITS  = 88;

   localparam logic [15:0] RATE_TABLE [3][3] = '{
      '{16'd44100, 16'd48000, 16'd32000},
      '{16'd22050, 16'd24000, 16'd16000},
      '{16'd11025, 16'd12000, 16'd8000}
   };

   localparam logic [8:0] KBPS_TABLE [3][3][14] = '{
      '{
         '{9'd32, 9'd64, 9'd96, 9'd128, 9'd160, 9'd192, 9'd224,
           9'd256, 9'd288, 9'd320, 9'd352, 9'd384, 9'd416, 9'd448},
         '{9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
           9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd384},
         '{9'd32, 9'd40, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96,
           9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320}
      },
      '{
         '{9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
           9'd128, 9'd144, 9'd160, 9'd176, 9'd192, 9'd224, 9'd256},
         '{9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
           9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160},
         '{9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
           9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160}
      },
      '{
         '{9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
           9'd128, 9'd144, 9'd160, 9'd176, 9'd192, 9'd224, 9'd256},
         '{9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
           9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160},
         '{9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
           9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160}
      }
   };

   function automatic logic [1:0] version_map(input logic [1:0] ver_bits);
      logic [1:0] ver;
      case (ver_bits)
         VER_BITS_MPEG1: ver = VER_MPEG1;
         VER_BITS_MPEG2: ver = VER_MPEG2;
         default:        ver = VER_MPEG25;
      endcase
      return ver;
   endfunction

   function automatic logic [8:0] kbps_lookup(input logic [1:0] ver, input logic [1:0] lay,
                                              input logic [3:0] br_idx);
      logic [1:0] v;
      logic [1:0] l;
      logic [3:0] i;
      v = (ver > 2'd2) ? 2'd2 : ver;
      l = (lay > 2'd2) ? 2'd2 : lay;
      i = (br_idx == 4'd0 || br_idx == 4'd15) ? 4'd0 : br_idx - 4'd1;
      return KBPS_TABLE[v][l][i];
   endfunction

   function automatic logic [15:0] rate_lookup(input logic [1:0] ver, input logic [1:0] sr_idx);
      logic [1:0] v;
      logic [1:0] s;
      v = (ver > 2'd2) ? 2'd2 : ver;
      s = (sr_idx > 2'd2) ? 2'd2 : sr_idx;
      return RATE_TABLE[v][s];
   endfunction

endpackage

`default_nettype wire

[hw/rtl/mpeg_audio_frame_header_finder_core.sv]
// Top level: byte-stream MPEG audio frame header finder with iterative frame-length divider.
`default_nettype none

// Takes one stream byte per request and tests the four bytes ending at it as an MPEG
// audio frame header. A byte that completes no header leaves the core ready for the
// next request. A byte that completes a header starts the frame-length computation:
// a step for the bitrate scaling multiply, twelve steps of the restoring divider
// (compare-and-subtract, one quotient bit each) and a step to load the response
// register, which waits while the response stalls; only then is the next request
// taken. req_tuser[0] marks the first byte of a new stream. Configuration: register 0
// is the start offset, register 1 the stop-after-first flag.
module mpeg_audio_frame_header_finder_core #(
   parameter int unsigned OFFSET_BITS = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] data_byte
   input  wire logic [0:0]  req_tuser,   // [0] stream_start
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   // [31:0] header_offset, [33:32] mpeg_version, [35:34] layer_index,
   // [36] crc_protected, [45:37] bitrate_kbps, [61:46] sample_rate_hz,
   // [62] padding_bit, [63] private_bit, [65:64] channel_mode,
   // [67:66] mode_extension, [71:68] misc_flags, [83:72] frame_length, [87:84] zero
   output      logic [mafhf_pkg::RSP_BITS-1:0] rsp_tdata,
   input  wire logic        csr_we,
   input  wire logic [0:0]  csr_index,
   input  wire logic [31:0] csr_wdata
);

   localparam int unsigned CMP_BITS = (OFFSET_BITS > 32) ? OFFSET_BITS : 32;
   localparam int unsigned QB = mafhf_pkg::QUOT_BITS;
   localparam int unsigned CNT_BITS = $clog2(QB);

   mafhf_pkg::state_type state_ff, state_in;

   logic [23:0]             win_ff, win_in;
   logic [1:0]              fill_ff, fill_in;
   logic [OFFSET_BITS-1:0]  off_ff, off_in;
   logic                    found_ff, found_in;
   logic [31:0]             start_off_ff, start_off_in;
   logic                    stop_first_ff, stop_first_in;
   logic                    rsp_valid_ff, rsp_valid_in;

   logic [31:0]             hdr_ff, hdr_in;
   logic [1:0]              ver_ff, ver_in;
   logic [1:0]              lay_ff, lay_in;
   logic                    crc_ff, crc_in;
   logic [8:0]              kbps_ff, kbps_in;
   logic [15:0]             hz_ff, hz_in;
   logic                    pad_ff, pad_in;
   logic                    priv_ff, priv_in;
   logic [7:0]              tail_ff, tail_in;
   logic [15:0]             rem_ff, rem_in;
   logic [QB-1:0]           low_ff, low_in;
   logic [QB-1:0]           quot_ff, quot_in;
   logic [CNT_BITS-1:0]     cnt_ff, cnt_in;
   logic [mafhf_pkg::RSP_BITS-1:0] rsp_data_ff, rsp_data_in;

   logic                    req_fire;
   logic                    clr;
   logic [23:0]             win_cur;
   logic [1:0]              fill_cur;
   logic [OFFSET_BITS-1:0]  off_cur;
   logic                    found_cur;
   logic [7:0]              b0, b1, b2, b3;
   logic [1:0]              ver_bits, lay_bits, sr_idx, ver_dec, lay_dec;
   logic [3:0]              br_idx;
   logic [OFFSET_BITS-1:0]  hdr_off;
   logic [CMP_BITS-1:0]     hdr_wide, start_wide;
   logic                    cand;
   logic [26:0]             prod;
   logic [16:0]             trial, diff;
   logic                    ge;
   logic [QB-1:0]           flen;

   assign req_tready = (state_ff == mafhf_pkg::ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign clr       = req_tuser[0];
   assign win_cur   = clr ? 24'd0 : win_ff;
   assign fill_cur  = clr ? 2'd0 : fill_ff;
   assign off_cur   = clr ? '0 : off_ff;
   assign found_cur = clr ? 1'b0 : found_ff;

   assign b0 = win_cur[23:16];
   assign b1 = win_cur[15:8];
   assign b2 = win_cur[7:0];
   assign b3 = req_tdata[7:0];

   assign ver_bits = b1[4:3];
   assign lay_bits = b1[2:1];
   assign br_idx   = b2[7:4];
   assign sr_idx   = b2[3:2];
   assign ver_dec  = mafhf_pkg::version_map(ver_bits);
   assign lay_dec  = 2'd3 - lay_bits;

   assign hdr_off    = off_cur - OFFSET_BITS'(3);
   assign hdr_wide   = CMP_BITS'(hdr_off);
   assign start_wide = CMP_BITS'(start_off_ff);

   assign cand = (fill_cur == 2'd3) && (b0 == mafhf_pkg::SYNC_BYTE) &&
                 ((b1 & mafhf_pkg::SYNC_MASK) == mafhf_pkg::SYNC_MASK) &&
                 (ver_bits != mafhf_pkg::VER_BITS_RESERVED) &&
                 (lay_bits != mafhf_pkg::LAY_BITS_RESERVED) &&
                 (br_idx != mafhf_pkg::BR_IDX_FREE) && (br_idx != mafhf_pkg::BR_IDX_BAD) &&
                 (sr_idx != mafhf_pkg::SR_IDX_RESERVED) &&
                 (hdr_wide >= start_wide) && !(stop_first_ff && found_cur);

   assign prod = 27'(kbps_ff) * ((lay_ff == mafhf_pkg::LAYER_I) ?
                 27'(mafhf_pkg::SCALE_LAYER_I) : 27'(mafhf_pkg::SCALE_LAYER_23));

   assign trial = {rem_ff, low_ff[QB-1]};
   assign ge    = trial >= {1'b0, hz_ff};
   assign diff  = trial - {1'b0, hz_ff};

   assign flen = quot_ff + ((lay_ff == mafhf_pkg::LAYER_I) ? QB'({pad_ff, 2'b00}) : QB'(pad_ff));

   always_comb begin
      state_in      = state_ff;
      win_in        = win_ff;
      fill_in       = fill_ff;
      off_in        = off_ff;
      found_in      = found_ff;
      start_off_in  = start_off_ff;
      stop_first_in = stop_first_ff;
      rsp_valid_in  = rsp_valid_ff;
      hdr_in        = hdr_ff;
      ver_in        = ver_ff;
      lay_in        = lay_ff;
      crc_in        = crc_ff;
      kbps_in       = kbps_ff;
      hz_in         = hz_ff;
      pad_in        = pad_ff;
      priv_in       = priv_ff;
      tail_in       = tail_ff;
      rem_in        = rem_ff;
      low_in        = low_ff;
      quot_in       = quot_ff;
      cnt_in        = cnt_ff;
      rsp_data_in   = rsp_data_ff;

      if (csr_we) begin
         unique case (csr_index)
            mafhf_pkg::REG_START_OFFSET: start_off_in  = csr_wdata;
            mafhf_pkg::REG_STOP_FIRST:   stop_first_in = csr_wdata[0];
            default: ;
         endcase
      end

      // drop the response once taken
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         mafhf_pkg::ST_IDLE: begin
            if (req_fire) begin
               win_in   = {win_cur[15:0], b3};
               fill_in  = (fill_cur == 2'd3) ? fill_cur : fill_cur + 2'd1;
               off_in   = off_cur + OFFSET_BITS'(1);
               found_in = found_cur;
               if (cand) begin
                  found_in = 1'b1;
                  hdr_in   = hdr_wide[31:0];
                  ver_in   = ver_dec;
                  lay_in   = lay_dec;
                  crc_in   = ~b1[0];
                  kbps_in  = mafhf_pkg::kbps_lookup(ver_dec, lay_dec, br_idx);
                  hz_in    = mafhf_pkg::rate_lookup(ver_dec, sr_idx);
                  pad_in   = b2[1];
                  priv_in  = b2[0];
                  tail_in  = b3;
                  state_in = mafhf_pkg::ST_MUL;
               end
            end
         end
         mafhf_pkg::ST_MUL: begin
            rem_in   = 16'(prod[mafhf_pkg::NUM_BITS-1:QB]);
            low_in   = prod[QB-1:0];
            quot_in  = '0;
            cnt_in   = CNT_BITS'(QB - 1);
            state_in = mafhf_pkg::ST_DIV;
         end
         mafhf_pkg::ST_DIV: begin
            rem_in  = ge ? diff[15:0] : trial[15:0];
            low_in  = {low_ff[QB-2:0], 1'b0};
            quot_in = {quot_ff[QB-2:0], ge};
            if (cnt_ff == '0) begin
               state_in = mafhf_pkg::ST_PUSH;
            end else begin
               cnt_in = cnt_ff - CNT_BITS'(1);
            end
         end
         mafhf_pkg::ST_PUSH: begin
            // hold until the response register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_data_in  = {4'd0, flen, tail_ff[3:0], tail_ff[5:4], tail_ff[7:6],
                               priv_ff, pad_ff, hz_ff, kbps_ff, crc_ff, lay_ff, ver_ff,
                               hdr_ff};
               rsp_valid_in = 1'b1;
               state_in     = mafhf_pkg::ST_IDLE;
            end
         end
         default: state_in = mafhf_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= mafhf_pkg::ST_IDLE;
         win_ff        <= 24'd0;
         fill_ff       <= 2'd0;
         off_ff        <= '0;
         found_ff      <= 1'b0;
         start_off_ff  <= 32'd0;
         stop_first_ff <= 1'b1;
         rsp_valid_ff  <= 1'b0;
         cnt_ff        <= '0;
      end else begin
         state_ff      <= state_in;
         win_ff        <= win_in;
         fill_ff       <= fill_in;
         off_ff        <= off_in;
         found_ff      <= found_in;
         start_off_ff  <= start_off_in;
         stop_first_ff <= stop_first_in;
         rsp_valid_ff  <= rsp_valid_in;
         cnt_ff        <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      hdr_ff      <= hdr_in;
      ver_ff      <= ver_in;
      lay_ff      <= lay_in;
      crc_ff      <= crc_in;
      kbps_ff     <= kbps_in;
      hz_ff       <= hz_in;
      pad_ff      <= pad_in;
      priv_ff     <= priv_in;
      tail_ff     <= tail_in;
      rem_ff      <= rem_in;
      low_ff      <= low_in;
      quot_ff     <= quot_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

`default_nettype wire
